// File: hdl/bpp_pkg.sv
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared constants and types for the positional popcount block.
// ----------------------------------------------------------------------------
package bpp_pkg;

  localparam int MAX_WORDS  = 8;
  localparam int WORD_BITS  = 64;
  localparam int COUNT_BITS = 32;
  localparam int TOTAL_BITS = 32;
  localparam int INDEX_BITS = 9;
  localparam int CMD_BITS   = 2;
  localparam int WPS_BITS   = 4;
  localparam int ROW_BITS   = $clog2(MAX_WORDS);
  localparam int COL_BITS   = $clog2(WORD_BITS);
  localparam int ROW_WIDTH  = WORD_BITS * COUNT_BITS;

  localparam logic [CMD_BITS-1:0] CMD_ACCUMULATE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_READ       = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR      = 2'd2;

  localparam logic [WPS_BITS-1:0]   WPS_RESET = WPS_BITS'(MAX_WORDS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [ROW_BITS-1:0]     row;
    logic [INDEX_BITS-1:0]   index;
    logic [WORD_BITS-1:0]    word;
  } op_t;

endpackage

// File: hdl/bpp_front.sv
// ----------------------------------------------------------------------------
// bpp_front
// Accepts commands, tracks the word position within the bitset and issues
// decoded operations to the queue.
// ----------------------------------------------------------------------------
module bpp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bpp_pkg::CMD_BITS-1:0]  cmd,
  input  logic [bpp_pkg::WORD_BITS-1:0] word,
  input  logic [bpp_pkg::INDEX_BITS-1:0] bit_index,
  input  logic                          cfg_we,
  input  logic [bpp_pkg::WPS_BITS-1:0]  cfg_wdata,
  input  logic                          q_full,
  output logic                          q_push,
  output bpp_pkg::op_t                  q_data
);
  import bpp_pkg::*;

  logic [WPS_BITS-1:0] words_per_set;
  logic [ROW_BITS-1:0] word_position;
  logic [ROW_BITS-1:0] word_position_next;
  logic [WPS_BITS-1:0] set_len;
  logic [ROW_BITS-1:0] cur_pos;
  logic [WPS_BITS-1:0] pos_inc;
  logic                accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (words_per_set == '0) begin
      set_len = WPS_BITS'(1);
    end else if (words_per_set > WPS_BITS'(MAX_WORDS)) begin
      set_len = WPS_BITS'(MAX_WORDS);
    end else begin
      set_len = words_per_set;
    end
    cur_pos = (WPS_BITS'(word_position) < set_len) ? word_position : '0;
    pos_inc = WPS_BITS'(cur_pos) + WPS_BITS'(1);
  end

  always_comb begin
    q_push             = 1'b0;
    q_data.kind        = OP_ACC;
    q_data.row         = cur_pos;
    q_data.index       = bit_index;
    q_data.word        = word;
    word_position_next = word_position;
    unique case (cmd)
      CMD_ACCUMULATE: begin
        q_push             = accept;
        word_position_next = (pos_inc >= set_len) ? '0 : pos_inc[ROW_BITS-1:0];
      end
      CMD_READ: begin
        q_push      = accept;
        q_data.kind = OP_READ;
        q_data.row  = bit_index[INDEX_BITS-1 -: ROW_BITS];
      end
      CMD_CLEAR: begin
        q_push             = accept;
        q_data.kind        = OP_CLEAR;
        word_position_next = '0;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_per_set <= WPS_RESET;
      word_position <= '0;
    end else begin
      if (cfg_we) begin
        words_per_set <= cfg_wdata;
      end
      if (accept) begin
        word_position <= word_position_next;
      end
    end
  end

endmodule

// File: hdl/bpp_queue.sv
// ----------------------------------------------------------------------------
// bpp_queue
// Two-entry queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
module bpp_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  bpp_pkg::op_t push_data,
  input  logic         pop,
  output bpp_pkg::op_t head,
  output logic         full,
  output logic         empty
);
  import bpp_pkg::*;

  op_t        entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = entries[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/bpp_back.sv
// ----------------------------------------------------------------------------
// bpp_back
// Executes operations on the counter rows: read-modify-write for accumulate,
// counter select for read, row valid clear for clear.
// ----------------------------------------------------------------------------
module bpp_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_empty,
  input  bpp_pkg::op_t                    q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bpp_pkg::TOTAL_BITS-1:0]  total,
  output logic [bpp_pkg::INDEX_BITS-1:0]  read_index
);
  import bpp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t                             state;
  state_t                             state_next;
  op_t                                cur;
  logic [MAX_WORDS-1:0]               row_valid;
  logic [ROW_WIDTH-1:0]               mem [MAX_WORDS];
  logic [ROW_WIDTH-1:0]               mem_rdata;
  logic [WORD_BITS-1:0][COUNT_BITS-1:0] row_data;
  logic [WORD_BITS-1:0][COUNT_BITS-1:0] row_new;
  logic [COUNT_BITS-1:0]              sel_count;
  logic                               out_free;
  logic                               mem_we;
  logic                               load_out;
  logic                               start;

  assign out_free = !out_valid || out_ready;
  assign start    = (state == ST_IDLE) && !q_empty;
  assign q_pop    = start;
  assign row_data = row_valid[cur.row] ? mem_rdata : '0;
  assign mem_we   = (state == ST_EXEC) && (cur.kind == OP_ACC);
  assign load_out = (state == ST_EXEC) && (cur.kind == OP_READ) && out_free;
  assign sel_count = row_data[cur.index[COL_BITS-1:0]];

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      if (cur.word[b] && (row_data[b] != COUNT_MAX)) begin
        row_new[b] = row_data[b] + COUNT_BITS'(1);
      end else begin
        row_new[b] = row_data[b];
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && (q_head.kind != OP_CLEAR)) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (mem_we || load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur.row] <= row_new;
    end
    if (start) begin
      mem_rdata <= mem[q_head.row];
      cur       <= q_head;
    end
    if (load_out) begin
      total      <= sel_count[TOTAL_BITS-1:0];
      read_index <= cur.index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (start && (q_head.kind == OP_CLEAR)) begin
        row_valid <= '0;
      end else if (mem_we) begin
        row_valid[cur.row] <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/bit_position_popcount_top.sv
// ----------------------------------------------------------------------------
// bit_position_popcount_top
// Positional population count over 64-bit words grouped into bitsets.
// ----------------------------------------------------------------------------
// A read passes through the queue entry, the back end's operation register
// and the total output register. The back end takes one operation at a time:
// accumulate and read return it to idle after the counter row update or the
// result load, while a clear is done as it is popped. Reset clears all counters
// through per-row valid bits, sets words_per_set to 8 and the word position to zero.
module bit_position_popcount_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bpp_pkg::CMD_BITS-1:0]    cmd,
  input  logic [bpp_pkg::WORD_BITS-1:0]   word,
  input  logic [bpp_pkg::INDEX_BITS-1:0]  bit_index,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bpp_pkg::TOTAL_BITS-1:0]  total,
  output logic [bpp_pkg::INDEX_BITS-1:0]  read_index,
  input  logic                            cfg_we,
  input  logic [bpp_pkg::WPS_BITS-1:0]    cfg_wdata
);
  import bpp_pkg::*;

  op_t  push_data;
  op_t  head;
  logic push;
  logic pop;
  logic full;
  logic empty;

  bpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .word      (word),
    .bit_index (bit_index),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (full),
    .q_push    (push),
    .q_data    (push_data)
  );

  bpp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  bpp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (empty),
    .q_head     (head),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .total      (total),
    .read_index (read_index)
  );

endmodule

// File: hdl/bpp_checker.sv
// ----------------------------------------------------------------------------
// bpp_checker
// Port-level checks for the positional popcount block.
// ----------------------------------------------------------------------------
module bpp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [bpp_pkg::TOTAL_BITS-1:0]  total,
  input logic [bpp_pkg::INDEX_BITS-1:0]  read_index
);

  a_out_clear_after_rst: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !out_valid)
    else $error("result pending right after reset");

  a_ready_after_rst: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> in_ready)
    else $error("input not ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total) && $stable(read_index))
    else $error("stalled result changed");

endmodule

bind bit_position_popcount_top bpp_checker u_bpp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .total      (total),
  .read_index (read_index)
);

// File: bench/bit_position_popcount_top_test.sv
// ----------------------------------------------------------------------------
// bit_position_popcount_top_test
// Self-checking bench for the positional popcount block. A queue-fed driver
// sends accumulate, read, clear and unused transactions, a scoreboard keeps
// its own per-position tallies and word position, and every returned total
// is checked against the oldest predicted read. Runs through several
// words_per_set settings with random idling on both sides.
// ----------------------------------------------------------------------------
module bit_position_popcount_top_test;
  import bpp_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_POS      = WORD_BITS * MAX_WORDS;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_STALL   = 400;
  localparam int LIMIT_CYCLES = 400000;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 152;

  typedef struct {
    logic [CMD_BITS-1:0]   code;
    logic [WORD_BITS-1:0]  bits;
    logic [INDEX_BITS-1:0] idx;
  } stream_item_t;

  typedef struct {
    logic [TOTAL_BITS-1:0] total;
    logic [INDEX_BITS-1:0] index;
  } read_total_t;

  logic                  clk;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [CMD_BITS-1:0]   cmd        = '0;
  logic [WORD_BITS-1:0]  word       = '0;
  logic [INDEX_BITS-1:0] bit_index  = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [TOTAL_BITS-1:0] total;
  logic [INDEX_BITS-1:0] read_index;
  logic                  cfg_we     = 1'b0;
  logic [WPS_BITS-1:0]   cfg_wdata  = '0;

  stream_item_t pending_ops[$];
  read_total_t  reads_due[$];
  stream_item_t next_op;
  read_total_t  want;

  logic [COUNT_BITS-1:0] tally [NUM_POS];
  int unsigned           word_pos;
  logic [WPS_BITS-1:0]   wps_setting;

  int unsigned pushed;
  int unsigned accepted;
  int unsigned mismatches;
  int unsigned totals_checked;
  int unsigned seen_by_code [4];
  int unsigned settings_used;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned stall_left;
  int unsigned stall_asked;
  int unsigned stall_seen;
  int unsigned cycle_count;

  bit_position_popcount_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .word       (word),
    .bit_index  (bit_index),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .total      (total),
    .read_index (read_index),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned active_words(logic [WPS_BITS-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WORDS) return MAX_WORDS;
    return v;
  endfunction

  task automatic tally_transaction(input logic [CMD_BITS-1:0] code,
                                   input logic [WORD_BITS-1:0] bits,
                                   input logic [INDEX_BITS-1:0] idx);
    int unsigned len;
    int unsigned row;
    int unsigned slot;
    read_total_t rec;
    len = active_words(wps_setting);
    case (code)
      CMD_ACCUMULATE: begin
        row = (word_pos < len) ? word_pos : 0;
        for (int b = 0; b < WORD_BITS; b++) begin
          if (bits[b]) begin
            slot = row * WORD_BITS + b;
            if (tally[slot] != COUNT_MAX) tally[slot] = tally[slot] + 1'b1;
          end
        end
        word_pos = (row + 1 >= len) ? 0 : row + 1;
      end
      CMD_READ: begin
        rec.index = idx;
        if (idx < NUM_POS) rec.total = TOTAL_BITS'(tally[idx]);
        else rec.total = '0;
        reads_due = {reads_due, rec};
      end
      CMD_CLEAR: begin
        foreach (tally[i]) tally[i] = '0;
        word_pos = 0;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        next_op = pending_ops.pop_front();
        in_valid  <= 1'b1;
        cmd       <= next_op.code;
        word      <= next_op.bits;
        bit_index <= next_op.idx;
        if ($urandom_range(0, 99) < send_idle_pct) send_gap <= $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      recv_gap   <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_seen != stall_asked) begin
      stall_seen <= stall_asked;
      stall_left <= LONG_STALL;
      out_ready  <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap  <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < recv_idle_pct) recv_gap <= $urandom_range(1, 16);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        accepted++;
        seen_by_code[cmd]++;
        tally_transaction(cmd, word, bit_index);
      end
      if (out_valid && out_ready) begin
        if (reads_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: total %0d read_index %0d", total, read_index);
        end else begin
          want = reads_due.pop_front();
          totals_checked++;
          if (total !== want.total || read_index !== want.index) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected total %0d index %0d, got total %0d index %0d",
                       want.total, want.index, total, read_index);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_item(input logic [CMD_BITS-1:0] code,
                           input logic [WORD_BITS-1:0] bits,
                           input logic [INDEX_BITS-1:0] idx);
    stream_item_t it;
    it.code = code;
    it.bits = bits;
    it.idx  = idx;
    pending_ops = {pending_ops, it};
    pushed++;
  endtask

  task automatic settle();
    while (accepted != pushed || reads_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_setting(input logic [WPS_BITS-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    wps_setting = v;
    settings_used++;
    @(posedge clk);
  endtask

  function automatic logic [WORD_BITS-1:0] random_word();
    logic [WORD_BITS-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: w = '1;
      1: w = '0;
      2: w = WORD_BITS'(1) << $urandom_range(0, WORD_BITS - 1);
      3, 4: w = w & {$urandom, $urandom} & {$urandom, $urandom};
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [INDEX_BITS-1:0] pick_index(int unsigned len);
    if ($urandom_range(0, 9) < 7) return INDEX_BITS'($urandom_range(0, len * WORD_BITS - 1));
    return INDEX_BITS'($urandom_range(0, 2**INDEX_BITS - 1));
  endfunction

  task automatic run_phase(input logic [WPS_BITS-1:0] setting, input int unsigned count,
                           input int unsigned send_pct, input int unsigned recv_pct,
                           input bit squeeze);
    int unsigned made;
    int unsigned len;
    int unsigned pick;
    int unsigned n;
    write_setting(setting);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (squeeze) stall_asked++;
    len  = active_words(setting);
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        for (int k = 0; k < len; k++)
          push_item(CMD_ACCUMULATE, random_word(), INDEX_BITS'($urandom));
        n = $urandom_range(0, 3);
        repeat (n) push_item(CMD_READ, {$urandom, $urandom}, pick_index(len));
        made += len + n;
      end else if (pick < 87) begin
        n = $urandom_range(1, 4);
        repeat (n) push_item(CMD_READ, {$urandom, $urandom}, pick_index(len));
        made += n;
      end else if (pick < 91) begin
        push_item(CMD_CLEAR, {$urandom, $urandom}, INDEX_BITS'($urandom));
        made++;
      end else if (pick < 96) begin
        push_item(CMD_UNUSED, {$urandom, $urandom}, INDEX_BITS'($urandom));
        made++;
      end else begin
        n = $urandom_range(1, len);
        repeat (n) push_item(CMD_ACCUMULATE, random_word(), INDEX_BITS'($urandom));
        made += n;
      end
    end
  endtask

  initial begin
    logic [WPS_BITS-1:0] plan [NUM_PHASES];
    int unsigned sp;
    int unsigned rp;

    foreach (tally[i]) tally[i] = '0;
    word_pos      = 0;
    wps_setting   = WPS_RESET;
    send_idle_pct = 20;
    recv_idle_pct = 20;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset state, then a partly filled eight-word set
    push_item(CMD_READ, '0, 9'd0);
    push_item(CMD_READ, '1, 9'd511);
    push_item(CMD_ACCUMULATE, '1, '0);
    push_item(CMD_ACCUMULATE, '0, '1);
    push_item(CMD_ACCUMULATE, 64'h8000_0000_0000_0001, '0);
    push_item(CMD_ACCUMULATE, 64'h5555_5555_5555_5555, '0);
    push_item(CMD_ACCUMULATE, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    push_item(CMD_UNUSED, '1, '1);
    push_item(CMD_READ, '0, 9'd0);
    push_item(CMD_READ, '0, 9'd63);
    push_item(CMD_READ, '0, 9'd256);
    push_item(CMD_READ, '0, 9'd511);

    // lower the set length below the current word position
    write_setting(4'd3);
    push_item(CMD_ACCUMULATE, '1, '0);
    push_item(CMD_ACCUMULATE, '1, '0);
    push_item(CMD_READ, '0, 9'd0);
    push_item(CMD_READ, '0, 9'd64);

    // zero acts as one word per set
    write_setting(4'd0);
    push_item(CMD_ACCUMULATE, 64'h1, '0);
    push_item(CMD_READ, '0, 9'd0);
    push_item(CMD_CLEAR, '1, '1);
    push_item(CMD_READ, '0, 9'd0);
    push_item(CMD_READ, '0, 9'd64);

    plan = '{4'd15, 4'd1, 4'd8, 4'd0, 4'd3, 4'd8, 4'd2, 4'd0, 4'd5, 4'd7, 4'd8, 4'd0};
    plan[7] = WPS_BITS'($urandom_range(0, 15));
    plan[11] = WPS_BITS'($urandom_range(0, 15));

    for (int p = 0; p < NUM_PHASES; p++) begin
      sp = (p % 3 == 0) ? 0 : $urandom_range(5, 40);
      rp = (p % 4 == 1) ? 0 : $urandom_range(5, 40);
      if (p == NUM_PHASES - 1) begin
        sp = 0;
        rp = 0;
      end
      run_phase(plan[p], PHASE_ITEMS, sp, rp, p == 5);
    end

    settle();
    $display("Covered %0d accumulates, %0d reads, %0d clears, %0d unused commands",
             seen_by_code[CMD_ACCUMULATE], seen_by_code[CMD_READ],
             seen_by_code[CMD_CLEAR], seen_by_code[CMD_UNUSED]);
    $display("over %0d words_per_set writes; %0d totals checked, one long output stall",
             settings_used, totals_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
